[src/sfr_pkg.sv]
// sfr_pkg: shared types and constants for the sbus frame receiver
// used by the interfaces, the framer, the frame queue, the unpacker and the top level
// no dependencies
package sfr_pkg;

    // stream markers
    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] FTR_BYTE   = 8'h00;
    localparam logic [3:0] FTR_NIBBLE = 4'h4;

    // frame layout: 22 channel bytes then one flag byte
    localparam int unsigned STORE_BYTES   = 23;
    localparam int unsigned STORE_BITS    = STORE_BYTES * 8;
    localparam int unsigned PAYLOAD_BITS  = 176;
    localparam int unsigned CH_BITS       = 11;
    localparam int unsigned FLAG_LSB      = PAYLOAD_BITS;

    // byte position codes
    localparam logic [4:0] POS_HUNT   = 5'd0;
    localparam logic [4:0] POS_LAST   = 5'd23;
    localparam logic [4:0] POS_FOOTER = 5'd24;

    // last channel index per mode
    localparam logic [3:0] LAST_CH_HALF = 4'd7;
    localparam logic [3:0] LAST_CH_FULL = 4'd15;

    // queue depth between framer and unpacker
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef logic [7:0]              sfr_byte_t;
    typedef logic [CH_BITS-1:0]      sfr_chval_t;
    typedef logic [3:0]              sfr_chidx_t;

    // one decoded frame as handed from framer to unpacker
    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    ch17;
        logic                    ch18;
        logic                    lost;
        logic                    failsafe;
        logic                    full_mode;
    } sfr_frame_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } sfr_q_status_t;

    // header predecessor and footer check
    function automatic logic marker_ok(input logic [7:0] b);
        return (b == FTR_BYTE) || (b[3:0] == FTR_NIBBLE);
    endfunction

endpackage

[src/sfr_if.sv]
// sfr_if: valid/ready channel interfaces for input bytes and decoded channel words
// depends on sfr_pkg
interface sfr_byte_if;
    logic               valid;
    logic               ready;
    sfr_pkg::sfr_byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
    logic                valid;
    logic                ready;
    sfr_pkg::sfr_chidx_t channel_index;
    sfr_pkg::sfr_chval_t channel_value;
    logic                digital_ch17;
    logic                digital_ch18;
    logic                frame_lost;
    logic                failsafe_flag;
    logic                last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output digital_ch17, output digital_ch18, output frame_lost,
                    output failsafe_flag, output last_channel, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input digital_ch17, input digital_ch18, input frame_lost,
                    input failsafe_flag, input last_channel, output ready);
endinterface

[src/sfr_framer.sv]
// sfr_framer: front part, hunts for the header, collects 23 bytes, checks the footer
// depends on sfr_pkg and sfr_if; pushes whole frames into sfr_queue
module sfr_framer (
    input  logic                  clk,
    input  logic                  rst_n,
    sfr_byte_if.sink              rx_in,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  sfr_pkg::sfr_q_status_t q_status,
    output logic                  push,
    output sfr_pkg::sfr_frame_t   push_frame
);

    logic [4:0]                      pos_reg, pos_next;
    logic [7:0]                      prev_reg;
    logic [sfr_pkg::STORE_BITS-1:0]  store_reg;
    logic                            mode_reg;
    logic                            accept;

    // only the footer word waits for queue room
    assign rx_in.ready = !((pos_reg == sfr_pkg::POS_FOOTER) && q_status.full);
    assign accept      = rx_in.valid && rx_in.ready;

    // position update
    always_comb
    begin
        pos_next = pos_reg;
        if (pos_reg == sfr_pkg::POS_HUNT)
        begin
            if ((rx_in.rx_byte == sfr_pkg::HDR_BYTE) && sfr_pkg::marker_ok(prev_reg))
                pos_next = 5'd1;
        end
        else if (pos_reg <= sfr_pkg::POS_LAST)
            pos_next = pos_reg + 5'd1;
        else
            pos_next = sfr_pkg::POS_HUNT;
    end

    // frame push on a good footer
    assign push = accept && (pos_reg == sfr_pkg::POS_FOOTER)
                  && sfr_pkg::marker_ok(rx_in.rx_byte);

    always_comb
    begin
        push_frame.payload   = store_reg[sfr_pkg::PAYLOAD_BITS-1:0];
        push_frame.ch17      = mode_reg & store_reg[sfr_pkg::FLAG_LSB];
        push_frame.ch18      = mode_reg & store_reg[sfr_pkg::FLAG_LSB+1];
        push_frame.lost      = store_reg[sfr_pkg::FLAG_LSB+2];
        push_frame.failsafe  = store_reg[sfr_pkg::FLAG_LSB+3];
        push_frame.full_mode = mode_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= sfr_pkg::POS_HUNT;
            prev_reg <= sfr_pkg::FTR_BYTE;
            mode_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg  <= pos_next;
                prev_reg <= rx_in.rx_byte;
            end
            if (cfg_we)
                mode_reg <= cfg_wdata;
        end
    end

    // frame store as a byte shift line, first byte ends at the bottom
    always_ff @(posedge clk)
    begin
        if (accept && (pos_reg != sfr_pkg::POS_HUNT) && (pos_reg <= sfr_pkg::POS_LAST))
            store_reg <= {rx_in.rx_byte, store_reg[sfr_pkg::STORE_BITS-1:8]};
    end

endmodule

[src/sfr_queue.sv]
// sfr_queue: two-entry frame queue between framer and unpacker
// depends on sfr_pkg
module sfr_queue #(
    parameter int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sfr_pkg::sfr_frame_t    push_frame,
    input  logic                   pop,
    output sfr_pkg::sfr_frame_t    pop_frame,
    output sfr_pkg::sfr_q_status_t status
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sfr_pkg::sfr_frame_t entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign status.full  = (cnt_reg == CW'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign pop_frame    = entries[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_frame;
    end

endmodule

[src/sfr_unpacker.sv]
// sfr_unpacker: back part, shifts 11-bit channels out of a queued frame, one word a cycle
// while res_out is ready; depends on sfr_pkg and sfr_if; pops frames from sfr_queue
module sfr_unpacker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sfr_pkg::sfr_q_status_t q_status,
    input  sfr_pkg::sfr_frame_t    pop_frame,
    output logic                   pop,
    sfr_result_if.source           res_out
);

    logic                              active_reg;
    logic [3:0]                        ch_reg;
    logic [sfr_pkg::PAYLOAD_BITS-1:0]  sh_reg;
    logic                              c17_reg, c18_reg, lost_reg, fs_reg, full_reg;
    logic                              out_valid_reg;
    logic [3:0]                        out_idx_reg;
    logic [sfr_pkg::CH_BITS-1:0]       out_val_reg;
    logic                              out_c17_reg, out_c18_reg, out_lost_reg, out_fs_reg;
    logic                              out_last_reg;
    logic                              fire, last;

    assign pop  = !active_reg && !q_status.empty;
    assign fire = active_reg && (!out_valid_reg || res_out.ready);
    assign last = full_reg ? (ch_reg == sfr_pkg::LAST_CH_FULL)
                           : (ch_reg == sfr_pkg::LAST_CH_HALF);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= 1'b1;
                ch_reg     <= '0;
            end
            else if (fire)
            begin
                ch_reg <= ch_reg + 4'd1;
                if (last)
                    active_reg <= 1'b0;
            end
            if (fire)
                out_valid_reg <= 1'b1;
            else if (res_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // frame payload and output word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sh_reg   <= pop_frame.payload;
            c17_reg  <= pop_frame.ch17;
            c18_reg  <= pop_frame.ch18;
            lost_reg <= pop_frame.lost;
            fs_reg   <= pop_frame.failsafe;
            full_reg <= pop_frame.full_mode;
        end
        else if (fire)
            sh_reg <= sh_reg >> sfr_pkg::CH_BITS;
        if (fire)
        begin
            out_idx_reg  <= ch_reg;
            out_val_reg  <= sh_reg[sfr_pkg::CH_BITS-1:0];
            out_c17_reg  <= c17_reg;
            out_c18_reg  <= c18_reg;
            out_lost_reg <= lost_reg;
            out_fs_reg   <= fs_reg;
            out_last_reg <= last;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.channel_index = out_idx_reg;
    assign res_out.channel_value = out_val_reg;
    assign res_out.digital_ch17  = out_c17_reg;
    assign res_out.digital_ch18  = out_c18_reg;
    assign res_out.frame_lost    = out_lost_reg;
    assign res_out.failsafe_flag = out_fs_reg;
    assign res_out.last_channel  = out_last_reg;

endmodule

[src/sbus_frame_receiver_core.sv]
// sbus frame receiver: one input word a cycle; a good footer's frame goes via the queue
// and the unpacker's frame registers to the output register as its first channel word,
// then one channel word a cycle while res_out is ready (8 or 16 per frame), with a pause
// as the unpacker loads the next frame from the two-frame queue. input stalls only on a
// footer word while the queue holds two undelivered frames. reset (rst_n, async active low)
// clears position, previous byte (to 0x00), mode and queue; the frame store is not reset.
module sbus_frame_receiver_core #(
    parameter int unsigned QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    sfr_byte_if.sink     rx_in,
    sfr_result_if.source res_out,
    input  logic         cfg_we,
    input  logic         cfg_wdata
);

    logic                   push, pop;
    sfr_pkg::sfr_frame_t    push_frame, pop_frame;
    sfr_pkg::sfr_q_status_t q_status;

    // front: framing and footer check
    sfr_framer u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_in      (rx_in),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_status   (q_status),
        .push       (push),
        .push_frame (push_frame)
    );

    // frame queue
    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .status     (q_status)
    );

    // back: channel unpacking
    sfr_unpacker u_unpacker (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_frame (pop_frame),
        .pop       (pop),
        .res_out   (res_out)
    );

`ifndef SYNTHESIS
    // no frame pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("frame pushed into full queue");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("frame popped from empty queue");

    // last word of a frame is channel 7 or 15
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.last_channel) |->
        (res_out.channel_index == sfr_pkg::LAST_CH_HALF ||
         res_out.channel_index == sfr_pkg::LAST_CH_FULL))
        else $error("last channel flag on wrong index");

    // channels of a frame follow without gaps
    a_next_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.ready && !res_out.last_channel) |=>
        (res_out.valid && res_out.channel_index == $past(res_out.channel_index) + 4'd1))
        else $error("channel sequence broken");
`endif

endmodule
